>>> hdl/lbbc_pkg.sv
`timescale 1ns / 1ps

package lbbc_pkg;

    // fixed field widths of the request and result channels
    localparam int CMD_W      = 2;
    localparam int BLK_W      = 40;
    localparam int IDX_W      = 4;
    localparam int STAT_W     = 2;
    localparam int SHIFT_W    = 4;
    localparam int ACTIVE_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [SHIFT_W-1:0]  SHIFT_RST  = SHIFT_W'(2);
    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = ACTIVE_W'(16);

    // command codes
    localparam logic [CMD_W-1:0] CMD_GET     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DIRTY   = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_HIT      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DEADLOCK = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ACK      = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SCAN,
        ST_LAST,
        ST_FIN
    } t_state;

endpackage

>>> hdl/lru_block_buffer_cache.sv
`timescale 1ns / 1ps

// Fully associative block buffer cache with LRU order and pin marks.
// Request channel: i_valid / o_stall with i_command, i_block_number and
// i_target_entry; a request is taken at a clock edge with i_valid high and
// o_stall low. Result channel: o_valid / i_stall, one result per request.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 block shift, 1 active entries); write only while the block is idle.
// A get request passes through a shift step that forms the saturated
// disk block, a scan step with one tag read per active entry (the clamped
// active entry count) through the tag memory port, a last step for the
// final compare and a finish step that updates LRU, pin and tag state.
// Release, mark-dirty and no-op requests go straight to the finish step.
// The block takes no new request until the current one has finished.
// The scan shares one tag compare and two rank compares over all entries,
// so o_stall stays high from acceptance until the result is loaded.
// A loaded result waits in the output register while i_stall is high; the
// block takes the next request meanwhile and holds its own finish step
// until that register is free.
// Reset clears valid, pin and dirty marks, sets entry i to rank i and loads
// the configuration defaults; tag contents are left undefined.
module lru_block_buffer_cache #(
    parameter int ENTRIES    = 16,
    parameter int BLOCK_BITS = 40
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [lbbc_pkg::CMD_W-1:0]      i_command,
    input  logic [lbbc_pkg::BLK_W-1:0]      i_block_number,
    input  logic [lbbc_pkg::IDX_W-1:0]      i_target_entry,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [lbbc_pkg::STAT_W-1:0]     o_status,
    output logic [lbbc_pkg::IDX_W-1:0]      o_entry_index,
    output logic [lbbc_pkg::BLK_W-1:0]      o_disk_block,
    output logic                            o_writeback_needed,
    output logic [lbbc_pkg::BLK_W-1:0]      o_evicted_block,
    input  logic                            i_cfg_we,
    input  logic [lbbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lbbc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int BB = BLOCK_BITS;
    localparam int FW = lbbc_pkg::BLK_W;
    localparam int XW = lbbc_pkg::IDX_W;

    lbbc_pkg::t_state r_state, n_state;

    // configuration
    logic [lbbc_pkg::SHIFT_W-1:0]  r_shift;
    logic [lbbc_pkg::ACTIVE_W-1:0] r_active;

    // per-entry state
    logic [BB-1:0] r_tag_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid_m, r_pin_m, r_dirty_m;
    logic [IW-1:0]      r_rank [ENTRIES];

    // request
    logic [lbbc_pkg::CMD_W-1:0] r_cmd;
    logic [BB-1:0]              r_blk;
    logic [XW-1:0]              r_tgt;
    logic [BB-1:0]              r_db;

    // scan
    logic [CW-1:0] r_cnt;
    logic          r_rd_ok;
    logic [IW-1:0] r_rd_idx;
    logic [BB-1:0] r_rd_data;
    logic          r_hit_found, r_vic_found;
    logic [IW-1:0] r_hit_idx, r_vic_idx, r_hit_rank, r_vic_rank;
    logic          r_vic_valid, r_vic_dirty;
    logic [BB-1:0] r_vic_tag;

    // result register
    logic                        r_out_valid;
    logic [lbbc_pkg::STAT_W-1:0] r_out_status;
    logic [XW-1:0]               r_out_idx;
    logic [FW-1:0]               r_out_db, r_out_ev;
    logic                        r_out_wb;

    // control
    logic          w_accept, w_out_free, w_load, w_scan_rd, w_fin_get;
    logic [CW-1:0] w_n;
    logic [IW-1:0] w_scan_addr, w_rank_rd, w_fin_idx, w_fin_rank, w_tgt_idx;
    logic [BB-1:0] w_blk_in, w_mx_sh, w_db;
    logic          w_tgt_ok, w_mem_we, w_do_hit, w_do_vic;
    logic          w_hit_upd, w_vic_upd;
    logic [FW+BB-1:0] w_blk_ext;
    logic [BB+FW-1:0] w_db_ext, w_ev_ext;
    logic [IW+XW-1:0] w_fin_idx_ext, w_tgt_ext;
    logic [FW-1:0]    w_db_out, w_ev_out;
    logic [XW-1:0]    w_idx_out;

    // request width conversion and saturating shift
    assign w_blk_ext = {{BB{1'b0}}, i_block_number};
    assign w_blk_in  = w_blk_ext[BB-1:0];
    assign w_mx_sh   = {BB{1'b1}} >> r_shift;
    assign w_db      = (r_blk > w_mx_sh) ? {BB{1'b1}} : (r_blk << r_shift);

    // clamp active count to 1 .. ENTRIES
    always_comb begin
        if (r_active == '0) begin
            w_n = CW'(1);
        end else if (32'(r_active) > ENTRIES) begin
            w_n = CW'(ENTRIES);
        end else begin
            w_n = CW'(r_active);
        end
    end

    assign w_scan_addr = r_cnt[IW-1:0];
    assign w_rank_rd   = r_rank[r_rd_idx];

    // shared compare unit: one entry per cycle
    assign w_hit_upd = r_rd_ok && r_valid_m[r_rd_idx] && (r_rd_data == r_db) &&
                       (!r_hit_found || (w_rank_rd < r_hit_rank));
    assign w_vic_upd = r_rd_ok && !r_pin_m[r_rd_idx] &&
                       (!r_vic_found || (w_rank_rd > r_vic_rank));

    assign w_fin_get  = (r_cmd == lbbc_pkg::CMD_GET);
    assign w_do_hit   = w_load && w_fin_get && r_hit_found;
    assign w_do_vic   = w_load && w_fin_get && !r_hit_found && r_vic_found;
    assign w_mem_we   = w_do_vic;
    assign w_fin_idx  = r_hit_found ? r_hit_idx : r_vic_idx;
    assign w_fin_rank = r_hit_found ? r_hit_rank : r_vic_rank;

    assign w_tgt_ok  = 32'(r_tgt) < ENTRIES;
    assign w_tgt_ext = {{IW{1'b0}}, r_tgt};
    assign w_tgt_idx = w_tgt_ext[IW-1:0];

    assign w_db_ext      = {{FW{1'b0}}, r_db};
    assign w_db_out      = w_db_ext[FW-1:0];
    assign w_ev_ext      = {{FW{1'b0}}, r_vic_tag};
    assign w_ev_out      = w_ev_ext[FW-1:0];
    assign w_fin_idx_ext = {{XW{1'b0}}, w_fin_idx};
    assign w_idx_out     = w_fin_idx_ext[XW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lbbc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_command == lbbc_pkg::CMD_GET) ?
                              lbbc_pkg::ST_SHIFT : lbbc_pkg::ST_FIN;
                end
            end
            lbbc_pkg::ST_SHIFT: n_state = lbbc_pkg::ST_SCAN;
            lbbc_pkg::ST_SCAN: begin
                if (CW'(r_cnt + 1'b1) == w_n) begin
                    n_state = lbbc_pkg::ST_LAST;
                end
            end
            lbbc_pkg::ST_LAST: n_state = lbbc_pkg::ST_FIN;
            lbbc_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_state = lbbc_pkg::ST_IDLE;
                end
            end
            default: n_state = lbbc_pkg::ST_IDLE;
        endcase
    end

    // state machine outputs
    always_comb begin
        o_stall    = (r_state != lbbc_pkg::ST_IDLE);
        w_accept   = i_valid && (r_state == lbbc_pkg::ST_IDLE);
        w_scan_rd  = (r_state == lbbc_pkg::ST_SCAN);
        w_out_free = !r_out_valid || !i_stall;
        w_load     = (r_state == lbbc_pkg::ST_FIN) && w_out_free;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lbbc_pkg::ST_IDLE;
            r_shift     <= lbbc_pkg::SHIFT_RST;
            r_active    <= lbbc_pkg::ACTIVE_RST;
            r_valid_m   <= '0;
            r_pin_m     <= '0;
            r_dirty_m   <= '0;
            r_out_valid <= 1'b0;
            r_rd_ok     <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= IW'(i);
            end
        end else begin
            r_state <= n_state;
            r_rd_ok <= w_scan_rd;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    lbbc_pkg::CFG_SHIFT:  r_shift <= i_cfg_data[lbbc_pkg::SHIFT_W-1:0];
                    lbbc_pkg::CFG_ACTIVE: r_active <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            // promote the chosen entry to most recent and pin it
            if (w_do_hit || w_do_vic) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_rank[i] < w_fin_rank) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
                r_rank[w_fin_idx] <= '0;
                r_pin_m[w_fin_idx] <= 1'b1;
            end
            if (w_do_vic) begin
                r_valid_m[w_fin_idx] <= 1'b1;
                r_dirty_m[w_fin_idx] <= 1'b0;
            end

            if (w_load && !w_fin_get && w_tgt_ok) begin
                case (r_cmd)
                    lbbc_pkg::CMD_RELEASE: r_pin_m[w_tgt_idx] <= 1'b0;
                    lbbc_pkg::CMD_DIRTY:   r_dirty_m[w_tgt_idx] <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    // tag memory: one read port for the scan, one write port for the fill
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_tag_mem[r_vic_idx] <= r_db;
        end
        if (w_scan_rd) begin
            r_rd_data <= r_tag_mem[w_scan_addr];
        end
    end

    // request and scan datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_command;
            r_blk <= w_blk_in;
            r_tgt <= i_target_entry;
        end
        if (r_state == lbbc_pkg::ST_SHIFT) begin
            r_db        <= w_db;
            r_cnt       <= '0;
            r_hit_found <= 1'b0;
            r_vic_found <= 1'b0;
        end
        if (w_scan_rd) begin
            r_cnt    <= CW'(r_cnt + 1'b1);
            r_rd_idx <= w_scan_addr;
        end
        if (w_hit_upd) begin
            r_hit_found <= 1'b1;
            r_hit_idx   <= r_rd_idx;
            r_hit_rank  <= w_rank_rd;
        end
        if (w_vic_upd) begin
            r_vic_found <= 1'b1;
            r_vic_idx   <= r_rd_idx;
            r_vic_rank  <= w_rank_rd;
            r_vic_tag   <= r_rd_data;
            r_vic_valid <= r_valid_m[r_rd_idx];
            r_vic_dirty <= r_dirty_m[r_rd_idx];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (!w_fin_get) begin
                r_out_status <= lbbc_pkg::STAT_ACK;
                r_out_idx    <= r_tgt;
                r_out_db     <= '0;
                r_out_wb     <= 1'b0;
                r_out_ev     <= '0;
            end else if (r_hit_found) begin
                r_out_status <= lbbc_pkg::STAT_HIT;
                r_out_idx    <= w_idx_out;
                r_out_db     <= w_db_out;
                r_out_wb     <= 1'b0;
                r_out_ev     <= '0;
            end else if (r_vic_found) begin
                r_out_status <= lbbc_pkg::STAT_MISS;
                r_out_idx    <= w_idx_out;
                r_out_db     <= w_db_out;
                r_out_wb     <= r_vic_valid && r_vic_dirty;
                r_out_ev     <= r_vic_valid ? w_ev_out : '0;
            end else begin
                r_out_status <= lbbc_pkg::STAT_DEADLOCK;
                r_out_idx    <= '0;
                r_out_db     <= '0;
                r_out_wb     <= 1'b0;
                r_out_ev     <= '0;
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out_status;
    assign o_entry_index      = r_out_idx;
    assign o_disk_block       = r_out_db;
    assign o_writeback_needed = r_out_wb;
    assign o_evicted_block    = r_out_ev;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block took a request without going busy");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbbc_pkg::ST_SCAN) |-> (r_cnt < w_n))
        else $error("scan counter ran past the active entries");

    a_chosen_pinned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_hit || w_do_vic) |=> r_pin_m[$past(w_fin_idx)])
        else $error("hit or filled entry not pinned");

    a_chosen_mru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_hit || w_do_vic) |=> (r_rank[$past(w_fin_idx)] == '0))
        else $error("hit or filled entry not most recent");

endmodule
